[rtl/bivs_pkg.sv]
// shared types, codes and constants of the bounded integer vector store
package bivs_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int FUNC_W    = 3;
    localparam int INDEX_W   = 8;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 9;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH     = 3'd0,
        OP_READ     = 3'd1,
        OP_REMOVE   = 3'd2,
        OP_CONTAINS = 3'd3,
        OP_CLEAR    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                      ok;
        logic signed [VALUE_W-1:0] data;
        logic [COUNT_W-1:0]        count;
    } result_t;

endpackage

[rtl/bivs_ifs.sv]
// request and response channel interfaces
interface bivs_req_if;
    logic                                valid;
    logic                                ready;
    logic [bivs_pkg::FUNC_W-1:0]         func;
    logic [bivs_pkg::INDEX_W-1:0]        index;
    logic signed [bivs_pkg::VALUE_W-1:0] value;

    modport source (output valid, output func, output index, output value, input ready);
    modport sink (input valid, input func, input index, input value, output ready);
endinterface

interface bivs_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                ok;
    logic signed [bivs_pkg::VALUE_W-1:0] data;
    logic [bivs_pkg::COUNT_W-1:0]        count;

    modport source (output valid, output ok, output data, output count, input ready);
    modport sink (input valid, input ok, input data, input count, output ready);
endinterface

[rtl/bivs_ram.sv]
// element memory: one write port, one read port with registered read data
module bivs_ram #(
    parameter int DEPTH = bivs_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [bivs_pkg::VALUE_W-1:0] wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [bivs_pkg::VALUE_W-1:0] rdata
);

    logic [bivs_pkg::VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/bivs_obuf.sv]
// result register between the controller and the response channel
module bivs_obuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  bivs_pkg::result_t res,
    output logic              can_load,
    bivs_rsp_if.source        rsp
);

    logic              valid_reg;
    logic              valid_next;
    bivs_pkg::result_t res_reg;

    assign can_load = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign rsp.valid = valid_reg;
    assign rsp.ok    = res_reg.ok;
    assign rsp.data  = res_reg.data;
    assign rsp.count = res_reg.count;

endmodule

[rtl/bivs_ctrl.sv]
// request sequencer: count register, element walk and memory access control
module bivs_ctrl #(
    parameter int DEPTH = bivs_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    bivs_req_if.sink                     req,
    output logic                         mem_we,
    output logic [AW-1:0]                mem_waddr,
    output logic [bivs_pkg::VALUE_W-1:0] mem_wdata,
    output logic                         mem_re,
    output logic [AW-1:0]                mem_raddr,
    input  logic [bivs_pkg::VALUE_W-1:0] mem_rdata,
    output logic                         load,
    output bivs_pkg::result_t            res,
    input  logic                         can_load
);

    bivs_pkg::state_t                     state_reg, state_next;
    logic [CNT_W-1:0]                     cnt_reg, cnt_next;
    logic [bivs_pkg::FUNC_W-1:0]          op_reg, op_next;
    logic [bivs_pkg::VALUE_W-1:0]         value_reg, value_next;
    logic [CNT_W-1:0]                     ptr_reg, ptr_next;
    logic [CNT_W-1:0]                     end_reg, end_next;
    logic                                 fire_reg, fire_next;
    logic [AW-1:0]                        fire_addr_reg, fire_addr_next;
    logic                                 ok_reg, ok_next;
    logic signed [bivs_pkg::VALUE_W-1:0]  data_reg, data_next;
    logic                                 issue;
    logic                                 idx_ok;

    assign req.ready = (state_reg == bivs_pkg::ST_IDLE);
    assign idx_ok    = (32'(req.index) < 32'(cnt_reg));
    assign res       = '{ok: ok_reg, data: data_reg, count: bivs_pkg::COUNT_W'(cnt_reg)};

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        value_next     = value_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        fire_next      = 1'b0;
        fire_addr_next = fire_addr_reg;
        ok_next        = ok_reg;
        data_next      = data_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        load           = 1'b0;
        issue          = 1'b0;
        case (state_reg)
            bivs_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.func;
                    value_next = req.value;
                    ok_next    = 1'b0;
                    data_next  = '0;
                    state_next = bivs_pkg::ST_DONE;
                    case (req.func)
                        bivs_pkg::OP_PUSH:
                        begin
                            if (cnt_reg < CNT_W'(DEPTH))
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cnt_reg[AW-1:0];
                                mem_wdata = req.value;
                                cnt_next  = cnt_reg + CNT_W'(1);
                                ok_next   = 1'b1;
                            end
                        end
                        bivs_pkg::OP_READ:
                        begin
                            if (idx_ok)
                            begin
                                ok_next    = 1'b1;
                                ptr_next   = CNT_W'(req.index);
                                end_next   = CNT_W'(req.index) + CNT_W'(1);
                                state_next = bivs_pkg::ST_WALK;
                            end
                        end
                        bivs_pkg::OP_REMOVE:
                        begin
                            if (idx_ok)
                            begin
                                ok_next    = 1'b1;
                                ptr_next   = CNT_W'(req.index) + CNT_W'(1);
                                end_next   = cnt_reg;
                                state_next = bivs_pkg::ST_WALK;
                            end
                        end
                        bivs_pkg::OP_CONTAINS:
                        begin
                            ptr_next   = '0;
                            end_next   = cnt_reg;
                            state_next = bivs_pkg::ST_WALK;
                        end
                        bivs_pkg::OP_CLEAR:
                        begin
                            cnt_next = '0;
                            ok_next  = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            bivs_pkg::ST_WALK:
            begin
                // one read issued per cycle, its data handled the cycle after
                issue = (ptr_reg < end_reg) && !(op_reg == bivs_pkg::OP_CONTAINS && ok_reg);
                mem_re    = issue;
                mem_raddr = ptr_reg[AW-1:0];
                if (issue)
                begin
                    ptr_next       = ptr_reg + CNT_W'(1);
                    fire_next      = 1'b1;
                    fire_addr_next = ptr_reg[AW-1:0];
                end
                if (fire_reg)
                begin
                    case (op_reg)
                        bivs_pkg::OP_READ:
                        begin
                            data_next = mem_rdata;
                        end
                        bivs_pkg::OP_CONTAINS:
                        begin
                            if (mem_rdata == value_reg)
                            begin
                                ok_next = 1'b1;
                            end
                        end
                        bivs_pkg::OP_REMOVE:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = fire_addr_reg - AW'(1);
                            mem_wdata = mem_rdata;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (!issue)
                begin
                    state_next = bivs_pkg::ST_DONE;
                    if (op_reg == bivs_pkg::OP_REMOVE)
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
            end
            bivs_pkg::ST_DONE:
            begin
                load = can_load;
                if (can_load)
                begin
                    state_next = bivs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bivs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bivs_pkg::ST_IDLE;
            cnt_reg   <= '0;
            fire_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fire_reg  <= fire_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        value_reg     <= value_next;
        ptr_reg       <= ptr_next;
        end_reg       <= end_next;
        fire_addr_reg <= fire_addr_next;
        ok_reg        <= ok_next;
        data_reg      <= data_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("element count above capacity");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> ptr_reg < cnt_reg)
        else $error("memory read at or beyond count");

    a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bivs_pkg::ST_WALK && fire_reg && op_reg == bivs_pkg::OP_REMOVE)
        |-> fire_addr_reg != '0)
        else $error("shift write below entry zero");

    a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bivs_pkg::ST_WALK && !issue && op_reg == bivs_pkg::OP_REMOVE)
        |=> cnt_reg == $past(cnt_reg) - CNT_W'(1))
        else $error("remove did not decrement count");

    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bivs_pkg::ST_DONE && !can_load)
        |=> state_reg == bivs_pkg::ST_DONE && $stable(cnt_reg) && $stable(ok_reg))
        else $error("pending result changed while output stalled");

endmodule

[rtl/bounded_int_vector_store.sv]
// top level of the bounded integer vector store
// usage:
//   req carries func, index and value; a request transfers when valid and
//   ready are high at a clock edge. rsp carries ok, data and count, one
//   response per request, in request order.
//   ready is high only while the sequencer is idle; one request is worked
//   on at a time.
//   push, clear, failed read or remove and unknown codes: the sequencer
//   goes from idle straight to done, loads the response into the response
//   register once it can take one, and only then takes the next request.
//   read fetches one entry; remove at i shifts the entries above i down;
//   contains walks from entry zero and stops once the value is found. the
//   walk moves one element per cycle through the single memory read port,
//   with each shift write of remove following its read in the next cycle.
//   a response register sits on rsp, so the next request is taken while a
//   finished response waits; a stalled receiver holds the response and,
//   once the next one is finished, holds off further requests.
//   reset empties the store (count zero) and drops any pending response;
//   entries keep no reset value and are never read before being written.
module bounded_int_vector_store #(
    parameter int DEPTH = bivs_pkg::DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bivs_req_if.sink   req,
    bivs_rsp_if.source rsp
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [bivs_pkg::VALUE_W-1:0] mem_wdata;
    logic                         mem_re;
    logic [AW-1:0]                mem_raddr;
    logic [bivs_pkg::VALUE_W-1:0] mem_rdata;
    logic                         load;
    logic                         can_load;
    bivs_pkg::result_t            res;

    bivs_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bivs_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .load      (load),
        .res       (res),
        .can_load  (can_load)
    );

    bivs_obuf u_obuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .res      (res),
        .can_load (can_load),
        .rsp      (rsp)
    );

endmodule

[dv/bounded_int_vector_store_test.sv]
// self-checking testbench for the bounded integer vector store
`timescale 1ns / 1ps

module bounded_int_vector_store_test;

    localparam int DEPTH = bivs_pkg::DEPTH_DEF;
    localparam int RST_CYCLES = 10;
    localparam int STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS = 10;
    localparam int POOL_SIZE = 16;

    // codes with no operation behind them
    localparam logic [bivs_pkg::FUNC_W-1:0] FUNC_SPARE_LO  = 3'd5;
    localparam logic [bivs_pkg::FUNC_W-1:0] FUNC_SPARE_MID = 3'd6;
    localparam logic [bivs_pkg::FUNC_W-1:0] FUNC_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic [bivs_pkg::FUNC_W-1:0]         func;
        logic [bivs_pkg::INDEX_W-1:0]        index;
        logic signed [bivs_pkg::VALUE_W-1:0] value;
    } request_t;

    logic clk;
    logic rst_n;

    bivs_req_if req_ch ();
    bivs_rsp_if rsp_ch ();

    bounded_int_vector_store #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // shadow of the store contents
    logic signed [bivs_pkg::VALUE_W-1:0] store_mem [DEPTH];
    int                                  store_count;

    request_t                            pending_requests [$];
    bivs_pkg::result_t                   expected_results [$];
    logic signed [bivs_pkg::VALUE_W-1:0] value_pool [POOL_SIZE];

    int   plan_count;
    int   n_queued;
    int   n_accepted;
    int   n_responses;
    int   n_ok;
    int   n_mismatch;
    int   idle_cycles;
    int   send_idle_pct;
    int   rsp_idle_pct;
    int   op_seen [8];
    logic req_xfer;
    logic rsp_stall;
    logic hold_go;

    always #2 clk = ~clk;

    function automatic bivs_pkg::result_t apply_request(
        logic [bivs_pkg::FUNC_W-1:0] f, logic [bivs_pkg::INDEX_W-1:0] idx,
        logic signed [bivs_pkg::VALUE_W-1:0] val);
        bivs_pkg::result_t r;
        r = '0;
        case (f)
            bivs_pkg::OP_PUSH:
                if (store_count < DEPTH)
                begin
                    store_mem[store_count] = val;
                    store_count++;
                    r.ok = 1'b1;
                end
            bivs_pkg::OP_READ:
                if (int'(idx) < store_count)
                begin
                    r.data = store_mem[idx];
                    r.ok = 1'b1;
                end
            bivs_pkg::OP_REMOVE:
                if (int'(idx) < store_count)
                begin
                    for (int i = int'(idx); i + 1 < store_count; i++)
                        store_mem[i] = store_mem[i + 1];
                    store_count--;
                    r.ok = 1'b1;
                end
            bivs_pkg::OP_CONTAINS:
                for (int i = 0; i < store_count; i++)
                    if (store_mem[i] == val)
                        r.ok = 1'b1;
            bivs_pkg::OP_CLEAR:
                begin
                    store_count = 0;
                    r.ok = 1'b1;
                end
            default:
                r = '0;
        endcase
        r.count = store_count[bivs_pkg::COUNT_W-1:0];
        return r;
    endfunction

    task automatic queue_item(logic [bivs_pkg::FUNC_W-1:0] f,
                              logic [bivs_pkg::INDEX_W-1:0] idx,
                              logic signed [bivs_pkg::VALUE_W-1:0] val);
        request_t q;
        q.func = f;
        q.index = idx;
        q.value = val;
        pending_requests.push_back(q);
        n_queued++;
        case (f)
            bivs_pkg::OP_PUSH:
                if (plan_count < DEPTH)
                    plan_count++;
            bivs_pkg::OP_REMOVE:
                if (int'(idx) < plan_count)
                    plan_count--;
            bivs_pkg::OP_CLEAR:
                plan_count = 0;
            default:
                plan_count = plan_count;
        endcase
    endtask

    function automatic logic signed [bivs_pkg::VALUE_W-1:0] pick_value();
        logic signed [bivs_pkg::VALUE_W-1:0] v;
        if ($urandom_range(1) == 0)
            v = value_pool[$urandom_range(POOL_SIZE - 1)];
        else
            v = $urandom;
        return v;
    endfunction

    task automatic queue_random_request();
        int                                  r;
        logic [bivs_pkg::INDEX_W-1:0]        idx;
        logic signed [bivs_pkg::VALUE_W-1:0] v;
        r = $urandom_range(99);
        if (plan_count > 0 && $urandom_range(9) < 8)
            idx = bivs_pkg::INDEX_W'($urandom_range(plan_count - 1));
        else
            idx = bivs_pkg::INDEX_W'($urandom_range(255));
        v = pick_value();
        if (r < 36 && plan_count < 64)
            queue_item(bivs_pkg::OP_PUSH, bivs_pkg::INDEX_W'($urandom), v);
        else if (r < 36)
            queue_item(bivs_pkg::OP_REMOVE, idx, v);
        else if (r < 56)
            queue_item(bivs_pkg::OP_READ, idx, v);
        else if (r < 70)
            queue_item(bivs_pkg::OP_REMOVE, idx, v);
        else if (r < 92)
            queue_item(bivs_pkg::OP_CONTAINS, idx, v);
        else if (r < 96)
            queue_item(bivs_pkg::OP_CLEAR, idx, v);
        else
            queue_item(FUNC_SPARE_LO + bivs_pkg::FUNC_W'($urandom_range(2)), idx, v);
    endtask

    // fill to capacity, overflow, walk the whole store, then remove, read and clear
    task automatic queue_fill_burst();
        while (plan_count < DEPTH)
            queue_item(bivs_pkg::OP_PUSH, bivs_pkg::INDEX_W'($urandom), pick_value());
        queue_item(bivs_pkg::OP_PUSH, bivs_pkg::INDEX_W'($urandom), pick_value());
        queue_item(bivs_pkg::OP_PUSH, 8'd0, 32'sh7fffffff);
        queue_item(bivs_pkg::OP_READ, 8'd255, pick_value());
        queue_item(bivs_pkg::OP_CONTAINS, 8'd0, value_pool[$urandom_range(POOL_SIZE - 1)]);
        queue_item(bivs_pkg::OP_CONTAINS, 8'd0, $urandom);
        queue_item(bivs_pkg::OP_REMOVE, 8'd0, pick_value());
        queue_item(bivs_pkg::OP_REMOVE, 8'd254, pick_value());
        queue_item(bivs_pkg::OP_REMOVE, 8'd255, pick_value());
        queue_item(bivs_pkg::OP_READ, 8'd253, pick_value());
        queue_item(bivs_pkg::OP_CLEAR, 8'd255, -32'sd1);
    endtask

    task automatic queue_directed();
        queue_item(bivs_pkg::OP_READ, 8'd0, 32'sd0);
        queue_item(bivs_pkg::OP_REMOVE, 8'd0, 32'sd0);
        queue_item(bivs_pkg::OP_CONTAINS, 8'd0, 32'sd0);
        queue_item(bivs_pkg::OP_PUSH, 8'd0, 32'sh7fffffff);
        queue_item(bivs_pkg::OP_PUSH, 8'd255, 32'sh80000000);
        queue_item(bivs_pkg::OP_PUSH, 8'd0, 32'sd0);
        queue_item(bivs_pkg::OP_PUSH, 8'd0, -32'sd1);
        queue_item(bivs_pkg::OP_PUSH, 8'd0, 32'sd1);
        queue_item(bivs_pkg::OP_READ, 8'd0, 32'sd0);
        queue_item(bivs_pkg::OP_READ, 8'd4, 32'sd0);
        queue_item(bivs_pkg::OP_READ, 8'd5, 32'sd0);
        queue_item(bivs_pkg::OP_READ, 8'd255, -32'sd1);
        queue_item(bivs_pkg::OP_CONTAINS, 8'd0, 32'sh80000000);
        queue_item(bivs_pkg::OP_CONTAINS, 8'd255, 32'sd12345);
        queue_item(bivs_pkg::OP_REMOVE, 8'd4, 32'sd0);
        queue_item(bivs_pkg::OP_REMOVE, 8'd0, 32'sd0);
        queue_item(bivs_pkg::OP_REMOVE, 8'd200, 32'sd0);
        queue_item(FUNC_SPARE_LO, 8'd255, -32'sd1);
        queue_item(FUNC_SPARE_MID, 8'd0, 32'sh7fffffff);
        queue_item(FUNC_SPARE_HI, 8'd1, 32'sd0);
        queue_item(bivs_pkg::OP_CLEAR, 8'd0, 32'sd0);
        queue_item(bivs_pkg::OP_READ, 8'd0, 32'sd0);
        queue_item(bivs_pkg::OP_CONTAINS, 8'd0, 32'sd0);
        queue_item(bivs_pkg::OP_PUSH, 8'd0, 32'sd42);
        queue_item(bivs_pkg::OP_READ, 8'd0, 32'sd0);
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || expected_results.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic report_mismatch(string what, bivs_pkg::result_t want,
                                   bivs_pkg::result_t got);
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
            $display("%0t: %s: expected ok %0b data %0d count %0d, got ok %0b data %0d count %0d",
                     $realtime, what, want.ok, want.data, want.count,
                     got.ok, got.data, got.count);
    endtask

    // request driver
    always @(negedge clk)
    begin : drive_req
        request_t nxt;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_xfer)
        begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_requests.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.func <= nxt.func;
                req_ch.index <= nxt.index;
                req_ch.value <= nxt.value;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // response receiver
    always @(negedge clk)
        rsp_ch.ready <= !rsp_stall && ($urandom_range(99) >= rsp_idle_pct);

    // long receiver hold-off while requests keep coming
    initial
    begin
        wait (hold_go);
        @(negedge clk);
        rsp_stall <= 1'b1;
        repeat (STALL_CYCLES) @(negedge clk);
        rsp_stall <= 1'b0;
    end

    // monitor, checker and watchdog
    always @(posedge clk)
    begin : monitor
        bivs_pkg::result_t want;
        bivs_pkg::result_t got;
        if (!rst_n)
            req_xfer <= 1'b0;
        else
        begin
            req_xfer <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready)
            begin
                expected_results.push_back(apply_request(req_ch.func, req_ch.index,
                                                         req_ch.value));
                op_seen[req_ch.func]++;
                n_accepted++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.ok = rsp_ch.ok;
                got.data = rsp_ch.data;
                got.count = rsp_ch.count;
                n_responses++;
                if (got.ok === 1'b1)
                    n_ok++;
                if (expected_results.size() == 0)
                    report_mismatch("transfer with nothing outstanding", '0, got);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.ok !== want.ok || got.data !== want.data || got.count !== want.count)
                        report_mismatch("response mismatch", want, got);
                end
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d of %0d requests taken",
                         idle_cycles, n_accepted, n_queued);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func = '0;
        req_ch.index = '0;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;
        req_xfer = 1'b0;
        rsp_stall = 1'b0;
        hold_go = 1'b0;
        store_count = 0;
        plan_count = 0;
        n_queued = 0;
        n_accepted = 0;
        n_responses = 0;
        n_ok = 0;
        n_mismatch = 0;
        idle_cycles = 0;
        foreach (op_seen[i])
            op_seen[i] = 0;
        foreach (store_mem[i])
            store_mem[i] = '0;
        value_pool[0] = 32'sh80000000;
        value_pool[1] = 32'sh7fffffff;
        value_pool[2] = 32'sd0;
        value_pool[3] = -32'sd1;
        for (int i = 4; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        send_idle_pct = 21;
        rsp_idle_pct = 85;
        repeat (RST_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_directed();
        repeat (350) queue_random_request();
        wait_drained();

        send_idle_pct = 85;
        rsp_idle_pct = 21;
        repeat (350) queue_random_request();
        wait_drained();

        send_idle_pct = 0;
        rsp_idle_pct = 0;
        hold_go = 1'b1;
        queue_fill_burst();
        repeat (150) queue_random_request();
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run: %0d requests, push %0d read %0d remove %0d contains %0d clear %0d",
                 n_accepted, op_seen[bivs_pkg::OP_PUSH], op_seen[bivs_pkg::OP_READ],
                 op_seen[bivs_pkg::OP_REMOVE], op_seen[bivs_pkg::OP_CONTAINS],
                 op_seen[bivs_pkg::OP_CLEAR]);
        $display("run: %0d spare codes, %0d responses (%0d ok), store filled past capacity, %0d mismatches",
                 op_seen[FUNC_SPARE_LO] + op_seen[FUNC_SPARE_MID] + op_seen[FUNC_SPARE_HI],
                 n_responses, n_ok, n_mismatch);
        if (expected_results.size() != 0)
            $display("%0d responses never arrived", expected_results.size());
        if (n_mismatch == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[bounded_int_vector_store.f]
rtl/bivs_pkg.sv
rtl/bivs_ifs.sv
rtl/bivs_ram.sv
rtl/bivs_obuf.sv
rtl/bivs_ctrl.sv
rtl/bounded_int_vector_store.sv
dv/bounded_int_vector_store_test.sv
